// ===== hw/rtl/mlpq_pkg.sv =====
// Shared types and constants for the multi-level priority FIFO.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mlpq_pkg;

   // Sizing of the per-level rings
   localparam int LEVELS            = 8;
   localparam int ENTRIES_PER_LEVEL = 16;

   // Field widths at the ports
   localparam int MODE_W   = 2;
   localparam int PRIO_W   = 3;
   localparam int TAG_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 4;

   // Derived widths
   localparam int LEVEL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SLOT_W   = $clog2(ENTRIES_PER_LEVEL);
   localparam int COUNT_W  = $clog2(ENTRIES_PER_LEVEL + 1);
   localparam int ADDR_W   = LEVEL_W + SLOT_W;
   localparam int MEM_DEPTH = LEVELS * ENTRIES_PER_LEVEL;
   localparam int LIM_W    = (LEVEL_W + 1 > CFG_W) ? LEVEL_W + 1 : CFG_W;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = 1;
   localparam int CMDQ_CNT_W = 2;

   // Input mode codes
   localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP_ANY = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEVEL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Reset value of the active level count
   localparam logic [CFG_W-1:0] ACTIVE_LEVELS_RESET = 4'd8;

   // Decoded operation handed from front to back
   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_POP_ANY,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PRIO_W-1:0]   prio;
      logic [TAG_W-1:0]    tag;
      logic [LEVELS-1:0]   active_mask;
   } cmd_type;

endpackage

// ===== hw/rtl/multi_level_priority_fifo.sv =====
// Multi-level strict-priority FIFO: one tag ring per priority level.
// Request channel (req_*): mode, priority_req and element, valid/ready.
// Response channel (rsp_*): element_out, level_out and status, one per request.
// csr_wr_en/csr_wr_data set the active level count; write only while idle.
// A request passes the front end's classifier into a two-entry command queue
// and is executed by the back end, which owns the pointers and tag memory.
// An accepted request is written into the command queue. An enqueue or an
// error then loads the response register; a dequeue first reads the registered
// tag memory. Enqueues and errors flow at one request per cycle while responses
// are taken; a dequeue holds the back end until its tag memory read returns.
// Reset empties every level, clears the command queue and response valid flag,
// and sets the active level count to eight; tag memory is not cleared.
// When the receiver stalls the response register holds its request result,
// the back end stops, and the queue fills before req_ready falls.
// Depends on mlpq_pkg, mlpq_front, mlpq_cmd_queue and mlpq_back.
`timescale 1ns / 1ps

module multi_level_priority_fifo import mlpq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [TAG_W-1:0]    req_element,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TAG_W-1:0]    rsp_element_out,
   output logic [PRIO_W-1:0]   rsp_level_out,
   output logic [STATUS_W-1:0] rsp_status
);

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type q_in_cmd, q_out_cmd;

   mlpq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_element      (req_element),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_in_cmd)
   );

   mlpq_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_out_cmd)
   );

   mlpq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_valid),
      .cmd             (q_out_cmd),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_element_out (rsp_element_out),
      .rsp_level_out   (rsp_level_out),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== hw/rtl/mlpq_front.sv =====
// Front end: holds the active level register, accepts requests and
// classifies them into commands. Depends on mlpq_pkg.
`timescale 1ns / 1ps

module mlpq_front import mlpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [PRIO_W-1:0] req_priority_req,
   input  logic [TAG_W-1:0]  req_element,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   logic [CFG_W-1:0] active_levels_ff;
   logic [LIM_W-1:0] limit;
   logic             prio_ok;

   // Active level count register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_levels_ff <= ACTIVE_LEVELS_RESET;
      end else if (csr_wr_en) begin
         active_levels_ff <= csr_wr_data;
      end
   end

   // Effective level count, clamped to the number of rings
   always_comb begin
      if (LIM_W'(active_levels_ff) > LIM_W'(LEVELS)) begin
         limit = LIM_W'(LEVELS);
      end else begin
         limit = LIM_W'(active_levels_ff);
      end
   end

   assign prio_ok = LIM_W'(req_priority_req) < limit;

   // Classify the request
   always_comb begin
      q_cmd.prio = req_priority_req;
      q_cmd.tag  = req_element;
      for (int i = 0; i < LEVELS; i++) begin
         q_cmd.active_mask[i] = LIM_W'(i) < limit;
      end
      unique case (req_mode)
         MODE_PUSH: begin
            q_cmd.op = prio_ok ? OP_PUSH : OP_REJECT;
         end
         MODE_POP: begin
            q_cmd.op = prio_ok ? OP_POP : OP_REJECT;
         end
         MODE_POP_ANY: begin
            q_cmd.op = OP_POP_ANY;
         end
         default: begin
            // unused mode reports a bad level on level zero
            q_cmd.op   = OP_REJECT;
            q_cmd.prio = '0;
         end
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid;

endmodule

// ===== hw/rtl/mlpq_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on mlpq_pkg.
`timescale 1ns / 1ps

module mlpq_cmd_queue import mlpq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type               slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = count_ff == CMDQ_CNT_W'(CMDQ_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/mlpq_back.sv =====
// Back end: per-level ring pointers, tag memory and result register.
// Executes one command at a time. Depends on mlpq_pkg.
`timescale 1ns / 1ps

module mlpq_back import mlpq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TAG_W-1:0]    rsp_element_out,
   output logic [PRIO_W-1:0]   rsp_level_out,
   output logic [STATUS_W-1:0] rsp_status
);

   // Sequencer states
   localparam logic S_EXEC = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;

   // Per-level ring state
   logic [SLOT_W-1:0]  head_ff  [LEVELS];
   logic [SLOT_W-1:0]  head_in  [LEVELS];
   logic [SLOT_W-1:0]  tail_ff  [LEVELS];
   logic [SLOT_W-1:0]  tail_in  [LEVELS];
   logic [COUNT_W-1:0] count_ff [LEVELS];
   logic [COUNT_W-1:0] count_in [LEVELS];

   // Tag memory
   logic [TAG_W-1:0]  tag_store_ff [MEM_DEPTH];
   logic [TAG_W-1:0]  rd_data_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;

   // Result register and pending dequeue level
   logic                rsp_valid_ff;
   logic [TAG_W-1:0]    rsp_element_ff;
   logic [PRIO_W-1:0]   rsp_level_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PRIO_W-1:0]   pend_level_ff, pend_level_in;

   logic                out_free, out_load;
   logic [TAG_W-1:0]    out_element;
   logic [PRIO_W-1:0]   out_level;
   logic [STATUS_W-1:0] out_status;

   logic [LEVELS-1:0]  nonempty;
   logic               any_found;
   logic [LEVEL_W-1:0] pick_lvl, sel_lvl;
   logic [COUNT_W-1:0] sel_count;
   logic [SLOT_W-1:0]  sel_head, sel_tail;
   logic               exec_go;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exec_go  = (state_ff == S_EXEC) && cmd_valid && out_free;
   assign cmd_pop  = exec_go;

   // Highest non-empty active level
   always_comb begin
      any_found = 1'b0;
      pick_lvl  = '0;
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0) && cmd.active_mask[i];
         if (nonempty[i]) begin
            any_found = 1'b1;
            pick_lvl  = LEVEL_W'(i);
         end
      end
   end

   assign sel_lvl   = (cmd.op == OP_POP_ANY) ? pick_lvl : LEVEL_W'(cmd.prio);
   assign sel_count = count_ff[sel_lvl];
   assign sel_head  = head_ff[sel_lvl];
   assign sel_tail  = tail_ff[sel_lvl];

   // Command execution
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      state_in      = state_ff;
      pend_level_in = pend_level_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = {sel_lvl, sel_tail};
      out_load      = 1'b0;
      out_element   = '0;
      out_level     = cmd.prio;
      out_status    = STATUS_OK;

      if (state_ff == S_READ) begin
         // deliver the tag held in the read data register
         if (out_free) begin
            out_load    = 1'b1;
            out_element = rd_data_ff;
            out_level   = pend_level_ff;
            state_in    = S_EXEC;
         end
      end else if (exec_go) begin
         unique case (cmd.op)
            OP_PUSH: begin
               out_load = 1'b1;
               if (sel_count == COUNT_W'(ENTRIES_PER_LEVEL)) begin
                  out_status = STATUS_FULL;
               end else begin
                  mem_we            = 1'b1;
                  mem_addr          = {sel_lvl, sel_tail};
                  tail_in[sel_lvl]  = (sel_tail == SLOT_W'(ENTRIES_PER_LEVEL - 1)) ?
                                      '0 : sel_tail + 1'b1;
                  count_in[sel_lvl] = sel_count + 1'b1;
               end
            end
            OP_POP, OP_POP_ANY: begin
               if ((cmd.op == OP_POP && sel_count == '0) ||
                   (cmd.op == OP_POP_ANY && !any_found)) begin
                  out_load   = 1'b1;
                  out_status = STATUS_EMPTY;
                  out_level  = (cmd.op == OP_POP) ? cmd.prio : '0;
               end else begin
                  mem_re            = 1'b1;
                  mem_addr          = {sel_lvl, sel_head};
                  pend_level_in     = PRIO_W'(sel_lvl);
                  state_in          = S_READ;
                  count_in[sel_lvl] = sel_count - 1'b1;
                  if (sel_count == COUNT_W'(1)) begin
                     // level drained: rewind both pointers
                     head_in[sel_lvl] = '0;
                     tail_in[sel_lvl] = '0;
                  end else begin
                     head_in[sel_lvl] = (sel_head == SLOT_W'(ENTRIES_PER_LEVEL - 1)) ?
                                        '0 : sel_head + 1'b1;
                  end
               end
            end
            OP_REJECT: begin
               out_load   = 1'b1;
               out_status = STATUS_BAD_LEVEL;
            end
            default: begin
               out_load   = 1'b1;
               out_status = STATUS_BAD_LEVEL;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXEC;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload and pending level
   always_ff @(posedge clock) begin
      pend_level_ff <= pend_level_in;
      if (out_load) begin
         rsp_element_ff <= out_element;
         rsp_level_ff   <= out_level;
         rsp_status_ff  <= out_status;
      end
   end

   // Tag memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_store_ff[mem_addr] <= cmd.tag;
      end
      if (mem_re) begin
         rd_data_ff <= tag_store_ff[mem_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element_out = rsp_element_ff;
   assign rsp_level_out   = rsp_level_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for multi_level_priority_fifo: directed and random requests
// checked against a per-level ring tracker kept in a small scoreboard class.
// Depends on mlpq_pkg and the multi_level_priority_fifo RTL.
`timescale 1ns / 1ps

module testbench;
   import mlpq_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int LONG_HOLD       = 250;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_REQUESTS  = 205;
   localparam int SETTING_COUNT   = 9;
   localparam int SHOWN_MISMATCHES = 40;

   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [PRIO_W-1:0]   level;
      logic [STATUS_W-1:0] status;
   } response_type;

   // Tracks every level ring and the responses still owed by the block
   class level_queue_tracker;
      logic [TAG_W-1:0] ring [LEVELS][ENTRIES_PER_LEVEL];
      int unsigned      head [LEVELS];
      int unsigned      tail [LEVELS];
      int unsigned      fill [LEVELS];
      logic [CFG_W-1:0] active_levels;
      response_type     owed [$];
      int unsigned      mismatches;
      int unsigned      requests;
      int unsigned      status_seen [4];

      function new();
         for (int lv = 0; lv < LEVELS; lv++) begin
            head[lv] = 0;
            tail[lv] = 0;
            fill[lv] = 0;
         end
         for (int s = 0; s < 4; s++) status_seen[s] = 0;
         active_levels = ACTIVE_LEVELS_RESET;
         mismatches    = 0;
         requests      = 0;
      endfunction

      function void set_levels(logic [CFG_W-1:0] value);
         active_levels = value;
      endfunction

      function int unsigned level_limit();
         return (active_levels > LEVELS) ? LEVELS : active_levels;
      endfunction

      // Oldest tag of a non-empty level; a drained level restarts at slot 0
      function logic [TAG_W-1:0] take_oldest(int lv);
         logic [TAG_W-1:0] tag;
         tag = ring[lv][head[lv]];
         fill[lv]--;
         if (fill[lv] == 0) begin
            head[lv] = 0;
            tail[lv] = 0;
         end else begin
            head[lv] = (head[lv] + 1) % ENTRIES_PER_LEVEL;
         end
         return tag;
      endfunction

      // Work out the response to an accepted request and queue it
      function void note_request(logic [MODE_W-1:0] mode, logic [PRIO_W-1:0] prio,
                                 logic [TAG_W-1:0] elem);
         response_type r;
         int unsigned  lim;
         int           lv;
         bit           found;
         lim      = level_limit();
         found    = 1'b0;
         r.tag    = '0;
         r.level  = prio;
         r.status = STATUS_OK;
         case (mode)
            MODE_PUSH: begin
               if (prio >= lim) begin
                  r.status = STATUS_BAD_LEVEL;
               end else if (fill[prio] >= ENTRIES_PER_LEVEL) begin
                  r.status = STATUS_FULL;
               end else begin
                  ring[prio][tail[prio]] = elem;
                  tail[prio] = (tail[prio] + 1) % ENTRIES_PER_LEVEL;
                  fill[prio]++;
               end
            end
            MODE_POP: begin
               if (prio >= lim) r.status = STATUS_BAD_LEVEL;
               else if (fill[prio] == 0) r.status = STATUS_EMPTY;
               else r.tag = take_oldest(prio);
            end
            MODE_POP_ANY: begin
               r.level  = '0;
               r.status = STATUS_EMPTY;
               // highest active non-empty level wins
               for (lv = int'(lim) - 1; lv >= 0 && !found; lv--) begin
                  if (fill[lv] != 0) begin
                     r.tag    = take_oldest(lv);
                     r.level  = lv[PRIO_W-1:0];
                     r.status = STATUS_OK;
                     found    = 1'b1;
                  end
               end
            end
            default: begin
               r.level  = '0;
               r.status = STATUS_BAD_LEVEL;
            end
         endcase
         owed.push_back(r);
         requests++;
         status_seen[r.status]++;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES) $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      task check_response(logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] level,
                          logic [STATUS_W-1:0] status);
         response_type want;
         if (owed.size() == 0) begin
            report($sformatf("response %h/%0d/%0d with no request outstanding",
                             tag, level, status));
         end else begin
            want = owed.pop_front();
            if (tag !== want.tag)
               report($sformatf("element_out %h, want %h", tag, want.tag));
            if (level !== want.level)
               report($sformatf("level_out %0d, want %0d", level, want.level));
            if (status !== want.status)
               report($sformatf("status %0d, want %0d", status, want.status));
         end
      endtask

      function int outstanding();
         return owed.size();
      endfunction

      task flush_leftovers();
         response_type want;
         while (owed.size() != 0) begin
            want = owed.pop_front();
            report($sformatf("response %h/%0d/%0d never arrived",
                             want.tag, want.level, want.status));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CFG_W-1:0]    csr_wr_data;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [PRIO_W-1:0]   req_priority_req;
   logic [TAG_W-1:0]    req_element;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [TAG_W-1:0]    rsp_element_out;
   logic [PRIO_W-1:0]   rsp_level_out;
   logic [STATUS_W-1:0] rsp_status;

   level_queue_tracker tracker = new();
   int unsigned        sent;
   int unsigned        taken;
   int unsigned        send_style;
   int unsigned        recv_style;
   int unsigned        quiet_cycles;
   logic [CFG_W-1:0]   level_settings [SETTING_COUNT] =
      '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd12, 4'd7};

   multi_level_priority_fifo uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_element_out  (rsp_element_out),
      .rsp_level_out    (rsp_level_out),
      .rsp_status       (rsp_status)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Idle gap before the next request or response, by style: none, a uniform draw, or mostly none
   function automatic int draw_gap(int unsigned style);
      case (style)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      endcase
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [PRIO_W-1:0] prio,
                               input logic [TAG_W-1:0] elem);
      int gap;
      gap = draw_gap(send_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_priority_req <= prio;
      req_element      <= elem;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(mode, prio, elem);
      sent++;
      if (sent % 50 == 0) send_style = $urandom_range(0, 2);
   endtask

   // Random request; bias steers levels toward full, toward empty, or neither
   task automatic send_random(input int unsigned bias);
      int unsigned      r;
      int unsigned      enq_pct;
      int unsigned      lim;
      logic [MODE_W-1:0] mode;
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  elem;
      enq_pct = (bias == 0) ? 70 : (bias == 1) ? 25 : 45;
      r = $urandom_range(0, 99);
      if (r < 3) mode = MODE_UNUSED;
      else if (r < 3 + enq_pct) mode = MODE_PUSH;
      else if ($urandom_range(0, 9) < 6) mode = MODE_POP;
      else mode = MODE_POP_ANY;
      lim = tracker.level_limit();
      if (lim > 0 && $urandom_range(0, 99) < 85) prio = PRIO_W'($urandom_range(0, lim - 1));
      else prio = PRIO_W'($urandom_range(0, LEVELS - 1));
      case ($urandom_range(0, 15))
         0: elem = '0;
         1: elem = '1;
         default: elem = $urandom();
      endcase
      send_request(mode, prio, elem);
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Stall detector: no request or response moving for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** multi_level_priority_fifo: FAILED **");
            $finish;
         end
      end
   end

   // Response side: random back-pressure plus two long hold-offs
   initial begin : response_side
      int hold;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 300 || taken == 1100) hold = LONG_HOLD;
         else hold = draw_gap(recv_style);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         tracker.check_response(rsp_element_out, rsp_level_out, rsp_status);
         taken++;
         if (taken % 50 == 0) recv_style = $urandom_range(0, 2);
      end
   end

   // Request side and run control
   initial begin : request_side
      int unsigned bias;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_mode         = MODE_PUSH;
      req_priority_req = '0;
      req_element      = '0;
      sent             = 0;
      taken            = 0;
      send_style       = 1;
      recv_style       = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every mode, empty, full and drained levels
      send_request(MODE_PUSH, 3'd0, 32'h0000_0000);
      send_request(MODE_PUSH, 3'd7, 32'hFFFF_FFFF);
      send_request(MODE_POP, 3'd7, 32'h1234_5678);
      send_request(MODE_POP_ANY, 3'd5, 32'hFFFF_FFFF);
      send_request(MODE_POP_ANY, 3'd0, 32'h0);
      send_request(MODE_POP, 3'd3, 32'h0);
      send_request(MODE_UNUSED, 3'd7, 32'hFFFF_FFFF);
      for (int i = 0; i < ENTRIES_PER_LEVEL + 1; i++)
         send_request(MODE_PUSH, 3'd5, (i % 2 == 0) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
      send_request(MODE_POP_ANY, 3'd0, 32'h0);
      drain_and_idle();

      // Random phases, each under a new active level count
      for (int s = 0; s < SETTING_COUNT; s++) begin
         csr_wr_en   <= 1'b1;
         csr_wr_data <= level_settings[s];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         tracker.set_levels(level_settings[s]);
         bias = 0;
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            if (i % 40 == 0) bias = $urandom_range(0, 2);
            send_random(bias);
         end
         drain_and_idle();
      end

      repeat (20) @(posedge clock);
      tracker.flush_leftovers();
      $display("Ran %0d requests through %0d active level settings (0, 1, 8 and 15 among them)",
               tracker.requests, SETTING_COUNT);
      $display("Responses: %0d ok, %0d bad level, %0d empty, %0d full; %0d mismatches",
               tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_BAD_LEVEL],
               tracker.status_seen[STATUS_EMPTY], tracker.status_seen[STATUS_FULL],
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("** multi_level_priority_fifo: PASSED **");
      end else begin
         $display("** multi_level_priority_fifo: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_front.sv
hw/rtl/mlpq_cmd_queue.sv
hw/rtl/mlpq_back.sv
hw/rtl/multi_level_priority_fifo.sv
dv/testbench.sv
